### sv/websocket_accept_key_generator_macros.svh
// Assertion macros for the websocket accept key generator.
`ifndef WEBSOCKET_ACCEPT_KEY_GENERATOR_MACROS_SVH
`define WEBSOCKET_ACCEPT_KEY_GENERATOR_MACROS_SVH
`ifndef SYNTHESIS
`define WAK_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m assertion failed");
`define WAK_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m assertion failed");
`else
`define WAK_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define WAK_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### sv/wsak_pkg.sv
// Shared types, constants and functions for the websocket accept key generator.
`default_nettype none
package wsak_pkg;
  localparam int MaxKeyBytes = 27;
  localparam int MagicLen = 36;
  localparam int KeyIdxW = 5;

  typedef enum logic [2:0] {
    ST_COLLECT, ST_LOAD, ST_ROUND, ST_FOLD, ST_EMIT, ST_ERROR
  } state_t;

  typedef struct packed {
    logic start;
    logic load_w;
    logic [31:0] w_in;
    logic round;
    logic fold;
  } core_ctl_t;

  function automatic logic [7:0] magic_byte(input logic [5:0] i);
    logic [7:0] r;
    r = 8'h00;
    case (i)
      6'd0: r = "2"; 6'd1: r = "5"; 6'd2: r = "8"; 6'd3: r = "E";
      6'd4: r = "A"; 6'd5: r = "F"; 6'd6: r = "A"; 6'd7: r = "5";
      6'd8: r = "-"; 6'd9: r = "E"; 6'd10: r = "9"; 6'd11: r = "1";
      6'd12: r = "4"; 6'd13: r = "-"; 6'd14: r = "4"; 6'd15: r = "7";
      6'd16: r = "D"; 6'd17: r = "A"; 6'd18: r = "-"; 6'd19: r = "9";
      6'd20: r = "5"; 6'd21: r = "C"; 6'd22: r = "A"; 6'd23: r = "-";
      6'd24: r = "C"; 6'd25: r = "5"; 6'd26: r = "A"; 6'd27: r = "B";
      6'd28: r = "0"; 6'd29: r = "D"; 6'd30: r = "C"; 6'd31: r = "8";
      6'd32: r = "5"; 6'd33: r = "B"; 6'd34: r = "1"; 6'd35: r = "1";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) r = 8'd65 + {2'b0, v};
    else if (v < 6'd52) r = 8'd71 + {2'b0, v};
    else if (v < 6'd62) r = {2'b0, v} - 8'd4;
    else if (v == 6'd62) r = "+";
    else r = "/";
    return r;
  endfunction
endpackage
`default_nettype wire

### sv/wsak_ram.sv
// Generic single-port-write RAM with registered read.
`default_nettype none
module wsak_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### sv/wsak_core.sv
// SHA-1 round unit: schedule window, working variables and chain value.
`default_nettype none
module wsak_core (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire wsak_pkg::core_ctl_t    ctl,
  input  wire logic [6:0]             round_idx,
  output logic      [159:0]           digest
);
  logic [31:0] w_r [16];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] h_r [5];
  logic [31:0] w_new, w_cur, f, k, tmp;
  logic [3:0] ti;

  assign ti = round_idx[3:0];

  always_comb begin
    w_new = w_r[(ti - 4'd3)] ^ w_r[(ti - 4'd8)] ^ w_r[(ti - 4'd14)] ^ w_r[ti];
    w_new = {w_new[30:0], w_new[31]};
    w_cur = (round_idx < 7'd16) ? w_r[ti] : w_new;
    if (round_idx < 7'd20) begin
      f = d_r ^ (b_r & (c_r ^ d_r)); k = 32'h5A827999;
    end else if (round_idx < 7'd40) begin
      f = b_r ^ c_r ^ d_r; k = 32'h6ED9EBA1;
    end else if (round_idx < 7'd60) begin
      f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r); k = 32'h8F1BBCDC;
    end else begin
      f = b_r ^ c_r ^ d_r; k = 32'hCA62C1D6;
    end
    tmp = {a_r[26:0], a_r[31:27]} + f + e_r + k + w_cur;
  end

  always_ff @(posedge clk) begin
    if (ctl.load_w) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= ctl.w_in;
    end
    if (ctl.round) begin
      if (round_idx >= 7'd16) w_r[ti] <= w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r[0] <= 32'h67452301; h_r[1] <= 32'hEFCDAB89; h_r[2] <= 32'h98BADCFE;
      h_r[3] <= 32'h10325476; h_r[4] <= 32'hC3D2E1F0;
      a_r <= '0; b_r <= '0; c_r <= '0; d_r <= '0; e_r <= '0;
    end else if (ctl.start) begin
      h_r[0] <= 32'h67452301; h_r[1] <= 32'hEFCDAB89; h_r[2] <= 32'h98BADCFE;
      h_r[3] <= 32'h10325476; h_r[4] <= 32'hC3D2E1F0;
      a_r <= 32'h67452301; b_r <= 32'hEFCDAB89; c_r <= 32'h98BADCFE;
      d_r <= 32'h10325476; e_r <= 32'hC3D2E1F0;
    end else if (ctl.round) begin
      e_r <= d_r; d_r <= c_r; c_r <= {b_r[1:0], b_r[31:2]};
      b_r <= a_r; a_r <= tmp;
    end else if (ctl.fold) begin
      h_r[0] <= h_r[0] + a_r; h_r[1] <= h_r[1] + b_r; h_r[2] <= h_r[2] + c_r;
      h_r[3] <= h_r[3] + d_r; h_r[4] <= h_r[4] + e_r;
      a_r <= h_r[0] + a_r; b_r <= h_r[1] + b_r; c_r <= h_r[2] + c_r;
      d_r <= h_r[3] + d_r; e_r <= h_r[4] + e_r;
    end
  end

  assign digest = {h_r[0], h_r[1], h_r[2], h_r[3], h_r[4]};
endmodule
`default_nettype wire

### sv/websocket_accept_key_generator.sv
// Top level: key collection, message build, SHA-1 sequencing, base64 output.
// Usage:
//   Input stream in_*: tdata = key_byte, tuser = byte_valid, tlast = key_last.
//   in_tready is held high while collecting; bytes beyond 27 are
//   dropped and flag an error. The request with tlast starts the hash, or on
//   overflow the error; in_tready stays low until the whole result run is taken.
//   Output stream out_*: tdata = accept_char, tuser = too_long, tlast marks
//   the final result ('=' or the error). 28 results per good key, one on error.
//   Each 64-byte block is loaded as 16 words of four bytes, each byte read
//   through the registered key store as an address phase and a data phase,
//   then runs 80 rounds on the shared round unit and one fold; keys over 19
//   bytes need two blocks. Then 28 characters go out, one per cycle when the
//   receiver is ready; a stall holds the current character.
//   Reset empties the key and restores the SHA-1 IV.
`default_nettype none
`include "websocket_accept_key_generator_macros.svh"
module websocket_accept_key_generator (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // key_byte
  input  wire logic       in_tuser,   // byte_valid
  input  wire logic       in_tlast,   // key_last
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // accept_char
  output logic            out_tuser,  // too_long
  output logic            out_tlast   // char_last
);
  wsak_pkg::state_t state_r, state_nxt;
  logic [4:0] len_r, len_nxt;
  logic ovf_r, ovf_nxt;
  logic blk_r, blk_nxt;          // current block index
  logic [6:0] cnt_r, cnt_nxt;    // byte position in block or round index
  logic [4:0] oc_r, oc_nxt;      // output char index
  logic [31:0] word_r, word_nxt;
  logic [1:0] bsub_r, bsub_nxt;
  logic [159:0] digest;
  logic two_blk;
  logic [6:0] msg_len;
  logic [7:0] pos;
  logic [7:0] mbyte;
  logic [7:0] key_rd;
  logic accept_in, accept_out;
  wsak_pkg::core_ctl_t ctl;
  logic [4:0] rd_addr;
  logic [5:0] sextet;
  logic [15:0] bits;

  assign accept_in = in_tvalid && in_tready;
  assign accept_out = out_tvalid && out_tready;
  assign msg_len = {2'b0, len_r} + 7'(wsak_pkg::MagicLen);
  assign two_blk = (msg_len + 7'd9) > 7'd64;
  assign bits = {6'b0, msg_len, 3'b0};

  // byte address within message; key store is read the cycle before the byte is used
  assign pos = {1'b0, blk_r, cnt_r[5:0]};
  assign rd_addr = pos[4:0];

  wsak_ram #(.Width(8), .Depth(32)) u_key (
    .clk(clk), .we(accept_in && in_tuser && (len_r < 5'(wsak_pkg::MaxKeyBytes))),
    .waddr(len_r), .wdata(in_tdata), .raddr(rd_addr), .rdata(key_rd)
  );

  always_comb begin
    logic [7:0] p;
    p = pos;
    if (p < {3'b0, len_r}) mbyte = key_rd;
    else if (p < {1'b0, msg_len}) mbyte = wsak_pkg::magic_byte(6'(p - {3'b0, len_r}));
    else if (p == {1'b0, msg_len}) mbyte = 8'h80;
    else if (p == (two_blk ? 8'd126 : 8'd62)) mbyte = bits[15:8];
    else if (p == (two_blk ? 8'd127 : 8'd63)) mbyte = bits[7:0];
    else mbyte = 8'h00;
  end

  wsak_core u_core (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .round_idx(cnt_r), .digest(digest)
  );

  // chain value holds steady while characters go out
  always_comb begin
    logic [4:0] g;
    logic [1:0] c;
    logic [23:0] v;
    g = 5'(oc_r >> 2);
    c = oc_r[1:0];
    if (g == 5'd6) v = {digest[15:0], 8'h00};
    else v = digest[159 - 24*g -: 24];
    sextet = v[23 - 6*c -: 6];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wsak_pkg::ST_COLLECT;
      len_r <= '0; ovf_r <= 1'b0; blk_r <= 1'b0; cnt_r <= '0; oc_r <= '0;
      bsub_r <= '0;
    end else begin
      state_r <= state_nxt;
      len_r <= len_nxt; ovf_r <= ovf_nxt; blk_r <= blk_nxt; cnt_r <= cnt_nxt;
      oc_r <= oc_nxt; bsub_r <= bsub_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    len_nxt = len_r; ovf_nxt = ovf_r; blk_nxt = blk_r; cnt_nxt = cnt_r;
    oc_nxt = oc_r; bsub_nxt = bsub_r; word_nxt = word_r;
    ctl = '0;
    in_tready = 1'b0;
    out_tvalid = 1'b0; out_tdata = 8'h00; out_tuser = 1'b0; out_tlast = 1'b0;
    unique case (state_r)
      wsak_pkg::ST_COLLECT: begin
        in_tready = 1'b1;
        if (accept_in) begin
          if (in_tuser) begin
            if (len_r < 5'(wsak_pkg::MaxKeyBytes)) len_nxt = len_r + 5'd1;
            else ovf_nxt = 1'b1;
          end
          if (in_tlast) begin
            if (ovf_nxt) state_nxt = wsak_pkg::ST_ERROR;
            else begin
              state_nxt = wsak_pkg::ST_LOAD;
              ctl.start = 1'b1;
              blk_nxt = 1'b0; cnt_nxt = '0; bsub_nxt = '0;
            end
          end
        end
      end
      wsak_pkg::ST_LOAD: begin
        // two-phase per byte: address then registered read data
        if (bsub_r == 2'd0) bsub_nxt = 2'd1;
        else begin
          bsub_nxt = 2'd0;
          word_nxt = {word_r[23:0], mbyte};
          if (cnt_r[1:0] == 2'd3) begin
            ctl.load_w = 1'b1;
            ctl.w_in = {word_r[23:0], mbyte};
          end
          if (cnt_r == 7'd63) begin
            cnt_nxt = '0;
            state_nxt = wsak_pkg::ST_ROUND;
          end else cnt_nxt = cnt_r + 7'd1;
        end
      end
      wsak_pkg::ST_ROUND: begin
        ctl.round = 1'b1;
        if (cnt_r == 7'd79) begin
          cnt_nxt = '0;
          state_nxt = wsak_pkg::ST_FOLD;
        end else cnt_nxt = cnt_r + 7'd1;
      end
      wsak_pkg::ST_FOLD: begin
        ctl.fold = 1'b1;
        if (two_blk && !blk_r) begin
          blk_nxt = 1'b1;
          state_nxt = wsak_pkg::ST_LOAD;
        end else begin
          oc_nxt = '0;
          state_nxt = wsak_pkg::ST_EMIT;
        end
      end
      wsak_pkg::ST_EMIT: begin
        out_tvalid = 1'b1;
        if (oc_r == 5'd27) begin
          out_tdata = "="; out_tlast = 1'b1;
        end else out_tdata = wsak_pkg::b64_char(sextet);
        if (accept_out) begin
          oc_nxt = oc_r + 5'd1;
          if (oc_r == 5'd27) begin
            state_nxt = wsak_pkg::ST_COLLECT;
            len_nxt = '0; ovf_nxt = 1'b0;
          end
        end
      end
      wsak_pkg::ST_ERROR: begin
        out_tvalid = 1'b1; out_tuser = 1'b1; out_tlast = 1'b1;
        if (accept_out) begin
          state_nxt = wsak_pkg::ST_COLLECT;
          len_nxt = '0; ovf_nxt = 1'b0;
        end
      end
      default: state_nxt = wsak_pkg::ST_COLLECT;
    endcase
  end

  `WAK_ASSERT_IMP(a_no_overlap, clk, rst_n, out_tvalid, !in_tready)
  `WAK_ASSERT_IMP(a_len_bound, clk, rst_n, 1'b1, len_r <= 5'(wsak_pkg::MaxKeyBytes))
  `WAK_ASSERT_IMP(a_err_only_flag, clk, rst_n, out_tvalid && out_tuser,
                  out_tlast && (out_tdata == 8'h00))
  `WAK_ASSERT_NXT(a_last_returns, clk, rst_n, accept_out && out_tlast, in_tready)
endmodule
`default_nettype wire
